@@ hw/rtl/lhc_pkg.sv @@
// Shared types, constants and literal tables for the loopback host classifier.
// Used by lhc_lane and loopback_host_classifier; depends on nothing else.
package lhc_pkg;

    localparam int unsigned LIT_COUNT = 3;
    localparam logic [3:0]  POS_MAX   = 4'd15;
    localparam logic [7:0]  BRACKET_L = 8'h5b;   // '['
    localparam logic [7:0]  BRACKET_R = 8'h5d;   // ']'

    // Per-lane recogniser state
    typedef struct packed {
        logic [3:0] pos;          // literal position, saturates at POS_MAX
        logic [2:0] alive;        // one bit per literal still matching
        logic [1:0] oct_idx;      // dotted-quad part index
        logic [1:0] digits;       // digits in the current part
        logic [7:0] value;        // value of the current part
        logic       first127;     // first part was 127
        logic       quad_alive;   // text can still be a strict dotted quad
    } t_lane_state;

    localparam t_lane_state LANE_INIT = '{
        pos: 4'd0, alive: 3'b111, oct_idx: 2'd0, digits: 2'd0,
        value: 8'd0, first127: 1'b0, quad_alive: 1'b1
    };

    // Lane control from the top level
    typedef struct packed {
        logic feed;    // take one byte
        logic clear;   // return to LANE_INIT (wins over feed)
    } t_lane_ctrl;

    // Length of each literal: localhost, ::1, 0:0:0:0:0:0:0:1
    function automatic logic [3:0] lit_len(input logic [1:0] k);
        logic [3:0] len;
        case (k)
            2'd0:    len = 4'd9;
            2'd1:    len = 4'd3;
            2'd2:    len = 4'd15;
            default: len = 4'd0;
        endcase
        return len;
    endfunction

    // Character of literal k at position p (zero past its end)
    function automatic logic [7:0] lit_char(input logic [1:0] k, input logic [3:0] p);
        logic [7:0] ch;
        ch = 8'h00;
        case (k)
            2'd0: begin
                case (p)
                    4'd0:    ch = "l";
                    4'd1:    ch = "o";
                    4'd2:    ch = "c";
                    4'd3:    ch = "a";
                    4'd4:    ch = "l";
                    4'd5:    ch = "h";
                    4'd6:    ch = "o";
                    4'd7:    ch = "s";
                    4'd8:    ch = "t";
                    default: ch = 8'h00;
                endcase
            end
            2'd1: begin
                case (p)
                    4'd0, 4'd1: ch = ":";
                    4'd2:       ch = "1";
                    default:    ch = 8'h00;
                endcase
            end
            2'd2: begin
                if (p == 4'd14)
                    ch = "1";
                else if (p == 4'd15)
                    ch = 8'h00;
                else if (p[0])
                    ch = ":";
                else
                    ch = "0";
            end
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

@@ hw/rtl/loopback_host_classifier.sv @@
// Top level of the loopback host classifier: input stage, bracket tracking,
// two recogniser lanes and the result register. Depends on lhc_pkg and lhc_lane.
//
// Usage:
//   The slave channel carries a host name, one byte per word, with tlast on
//   its final byte. Every byte is taken; only a word with tlast produces a
//   result word on the master channel, whose bit 0 is 1 when the host names
//   the local machine (localhost, ::1, 0:0:0:0:0:0:0:1 or 127.x.x.x as a
//   strict dotted quad, optionally wrapped in square brackets).
//   Throughput: one byte per cycle, except while a final byte waits on a
//   stalled result word; the lanes update between the input and result registers.
//   Path: a final byte is held in the input register, then its result word is
//   loaded into the result register once that register is empty or being taken.
//   Stall: while a result waits on m_axis_tready, non-final bytes keep
//   flowing; one final byte waits in the input register, and only then is
//   s_axis_tready lowered.
//   Reset: synchronous, active low; it empties both registers and returns
//   all recogniser state so the next byte starts a new host.
module loopback_host_classifier
    import lhc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,    // [7:0] host_byte
    input  logic       s_axis_tlast,    // final_byte
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata     // [0] is_loopback, [7:1] zero
);

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_final;
    logic       r_out_valid;
    logic       r_out_loop;
    logic       r_opened;
    logic [1:0] r_seen;

    logic       w_advance;
    logic [7:0] w_char;
    logic       w_hit0_fed;
    logic       w_hit1_now;
    logic       w_loop;
    t_lane_ctrl w_ctrl0;
    t_lane_ctrl w_ctrl1;

    // Process the held byte unless a final result cannot be stored
    assign w_advance     = r_in_valid && (!r_in_final || !r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_advance;

    // Fold upper case to lower case
    assign w_char = (r_in_byte inside {["A":"Z"]}) ? (r_in_byte + 8'h20) : r_in_byte;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_byte  <= s_axis_tdata;
            r_in_final <= s_axis_tlast;
        end
    end

    // Lane 0 sees every byte; lane 1 skips the first and the final byte
    always_comb begin
        w_ctrl0.feed  = w_advance && !r_in_final;
        w_ctrl0.clear = w_advance && r_in_final;
        w_ctrl1.feed  = w_advance && !r_in_final && (r_seen != 2'd0);
        w_ctrl1.clear = w_advance && r_in_final;
    end

    lhc_lane u_lane0 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (w_ctrl0),
        .i_byte  (w_char),
        .i_held  (1'b0),
        .o_hit   (w_hit0_fed)
    );

    lhc_lane u_lane1 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (w_ctrl1),
        .i_byte  (w_char),
        .i_held  (1'b1),
        .o_hit   (w_hit1_now)
    );

    // Lane 1 counts only when the brackets wrap the whole text
    assign w_loop = w_hit0_fed
                 || (r_opened && (r_seen != 2'd0) && (w_char == BRACKET_R) && w_hit1_now);

    // Track the opening bracket and saturating byte count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_opened <= 1'b0;
            r_seen   <= 2'd0;
        end else if (w_advance) begin
            if (r_in_final) begin
                r_opened <= 1'b0;
                r_seen   <= 2'd0;
            end else begin
                if (r_seen == 2'd0)
                    r_opened <= (w_char == BRACKET_L);
                if (r_seen != 2'd2)
                    r_seen <= r_seen + 2'd1;
            end
        end
    end

    // Result register: load on a final byte, drop once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance && r_in_final) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance && r_in_final)
            r_out_loop <= w_loop;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {7'd0, r_out_loop};

endmodule

@@ hw/rtl/lhc_lane.sv @@
// One recogniser lane: literal matcher and strict dotted-quad parser.
// Depends on lhc_pkg for the lane state type, literal tables and control struct.
module lhc_lane
    import lhc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_lane_ctrl i_ctrl,
    input  logic [7:0] i_byte,      // already folded to lower case
    input  logic       i_held,      // 1: match on the held state, 0: once this byte is taken
    output logic       o_hit
);

    t_lane_state r_state;
    t_lane_state n_state;
    logic [11:0] w_val;
    logic        w_digit;

    // Match test on a lane state
    function automatic logic lane_hit(input t_lane_state s);
        logic hit;
        hit = s.quad_alive && (s.oct_idx == 2'd3) && (s.digits != 2'd0) && s.first127;
        for (int k = 0; k < LIT_COUNT; k++) begin
            if (s.alive[k] && (s.pos == lit_len(2'(k))))
                hit = 1'b1;
        end
        return hit;
    endfunction

    assign w_digit = (i_byte inside {["0":"9"]});
    assign w_val   = 12'(r_state.value) * 12'd10 + 12'(i_byte - 8'h30);

    // Advance the state by one byte
    always_comb begin
        n_state = r_state;
        for (int k = 0; k < LIT_COUNT; k++) begin
            if (r_state.alive[k] && ((r_state.pos >= lit_len(2'(k)))
                    || (lit_char(2'(k), r_state.pos) != i_byte)))
                n_state.alive[k] = 1'b0;
        end
        if (r_state.pos < POS_MAX)
            n_state.pos = r_state.pos + 4'd1;

        if (r_state.quad_alive) begin
            if (w_digit) begin
                if ((r_state.digits == 2'd3)
                        || ((r_state.digits == 2'd1) && (r_state.value == 8'd0))
                        || (w_val > 12'd255)) begin
                    n_state.quad_alive = 1'b0;
                end else begin
                    n_state.value  = w_val[7:0];
                    n_state.digits = r_state.digits + 2'd1;
                end
            end else if (i_byte == ".") begin
                if ((r_state.digits == 2'd0) || (r_state.oct_idx == 2'd3)) begin
                    n_state.quad_alive = 1'b0;
                end else begin
                    if (r_state.oct_idx == 2'd0)
                        n_state.first127 = (r_state.value == 8'd127);
                    n_state.oct_idx = r_state.oct_idx + 2'd1;
                    n_state.digits  = 2'd0;
                    n_state.value   = 8'd0;
                end
            end else begin
                n_state.quad_alive = 1'b0;
            end
        end
    end

    assign o_hit = i_held ? lane_hit(r_state) : lane_hit(n_state);

    // Hold, advance or clear the lane state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= LANE_INIT;
        end else if (i_ctrl.clear) begin
            r_state <= LANE_INIT;
        end else if (i_ctrl.feed) begin
            r_state <= n_state;
        end
    end

endmodule

@@ hw/rtl/lhc_checker.sv @@
// Port-level checks for the loopback host classifier, bound to its top level.
// Depends only on the ports of loopback_host_classifier.
module lhc_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       s_axis_tvalid,
    input logic       s_axis_tready,
    input logic [7:0] s_axis_tdata,
    input logic       s_axis_tlast,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata
);

    // Reset empties the result register
    a_reset_out: assert property (@(posedge i_clk) !i_rst_n |=> !m_axis_tvalid)
        else $error("result word present after reset");

    // Input side is open straight out of reset
    a_reset_ready: assert property (@(posedge i_clk) $rose(i_rst_n) |-> s_axis_tready)
        else $error("input not ready after reset");

    // With no result waiting, the input is never blocked
    a_decoupled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input blocked with empty result register");

    // A stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled result word changed");

    // Padding bits of a result word stay zero
    a_out_pad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[7:1] == 7'd0))
        else $error("result padding not zero");

endmodule

bind loopback_host_classifier lhc_checker u_lhc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
